// File: hw/rtl/oblu_pkg.sv
`default_nettype none
package oblu_pkg;

	localparam int PRICE_W = 63;
	localparam int QTY_W   = 63;
	localparam int POS_W   = 6;

	typedef enum logic [1:0] {
		KIND_DELTA  = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_APPEND = 2'd2,
		KIND_TOP    = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ACT_UPDATED  = 3'd0,
		ACT_DELETED  = 3'd1,
		ACT_INSERTED = 3'd2,
		ACT_IGNORED  = 3'd3,
		ACT_CLEARED  = 3'd4,
		ACT_LOADED   = 3'd5
	} action_t;

	typedef struct packed {
		kind_t                kind;
		logic                 is_bid;
		logic [PRICE_W-1:0]   price;
		logic [QTY_W-1:0]     qty;
	} cmd_t;

	typedef struct packed {
		action_t              action;
		logic [POS_W-1:0]     position;
		logic [POS_W-1:0]     bid_depth;
		logic [POS_W-1:0]     ask_depth;
		logic [PRICE_W-1:0]   best_bid_price;
		logic [QTY_W-1:0]     best_bid_qty;
		logic [PRICE_W-1:0]   best_ask_price;
		logic [QTY_W-1:0]     best_ask_qty;
	} res_t;

endpackage
`default_nettype wire

// File: hw/rtl/oblu_front.sv
`default_nettype none
module oblu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [2:0]     in_user,
	input  wire logic [125:0]   in_data,
	output logic                q_valid,
	input  wire logic           q_ready,
	output oblu_pkg::cmd_t      q_cmd
);
	// two-entry queue between input and the book engine
	oblu_pkg::cmd_t mem_q [2];
	logic           wp_q, rp_q;
	logic [1:0]     cnt_q;
	oblu_pkg::cmd_t cmd;
	logic           push, pop;

	always_comb begin
		cmd.kind   = oblu_pkg::kind_t'(in_user[1:0]);
		cmd.is_bid = in_user[2];
		cmd.price  = in_data[62:0];
		cmd.qty    = in_data[125:63];
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_cmd    = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/oblu_side.sv
`default_nettype none
module oblu_side #(
	parameter int DEPTH = 32,
	parameter bit DESC  = 1'b1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        clr,
	input  wire oblu_pkg::cmd_t              cmd,
	output oblu_pkg::action_t                action,
	output logic [oblu_pkg::POS_W-1:0]       position,
	output logic [oblu_pkg::POS_W-1:0]       depth_nx,
	output logic [oblu_pkg::PRICE_W-1:0]     top_price,
	output logic [oblu_pkg::QTY_W-1:0]       top_qty
);
	localparam int CW = $clog2(DEPTH + 1);

	logic [oblu_pkg::PRICE_W-1:0] pr_q [DEPTH];
	logic [oblu_pkg::QTY_W-1:0]   qt_q [DEPTH];
	logic [CW-1:0]                cnt_q;

	logic [DEPTH-1:0] live, match, gt, first_m, after_m, after_i;
	logic             any_m, full;
	logic [CW-1:0]    midx, iidx, cnt_nx;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			live[i]  = (CW'(i) < cnt_q);
			match[i] = live[i] && (pr_q[i] == cmd.price);
			gt[i]    = live[i] && (DESC ? (cmd.price > pr_q[i]) : (cmd.price < pr_q[i]));
		end
		first_m = match & (~match + DEPTH'(1));
		any_m   = |match;
		// first compare hit, or the end of the list
		midx = '0;
		iidx = cnt_q;
		for (int i = DEPTH - 1; i >= 0; i--) begin
			if (match[i]) midx = CW'(i);
			if (gt[i]) iidx = CW'(i);
		end
		// the matching level and everything above it
		after_m = ~(first_m - DEPTH'(1)) & {DEPTH{any_m}};
		after_i = '0;
		for (int i = 0; i < DEPTH; i++) after_i[i] = (CW'(i) > iidx);
		full = (cnt_q >= CW'(DEPTH));
	end

	logic do_del, do_upd, do_ins, do_app, do_top;

	always_comb begin
		do_del = 1'b0; do_upd = 1'b0; do_ins = 1'b0; do_app = 1'b0; do_top = 1'b0;
		action   = oblu_pkg::ACT_IGNORED;
		position = '0;
		cnt_nx   = cnt_q;
		if (en) begin
			case (cmd.kind)
				oblu_pkg::KIND_DELTA: begin
					if (any_m) begin
						position = oblu_pkg::POS_W'(midx);
						if (cmd.qty == '0) begin
							do_del = 1'b1;
							action = oblu_pkg::ACT_DELETED;
							cnt_nx = cnt_q - CW'(1);
						end else begin
							do_upd = 1'b1;
							action = oblu_pkg::ACT_UPDATED;
						end
					end else if (cmd.qty != '0 && !full) begin
						do_ins   = 1'b1;
						action   = oblu_pkg::ACT_INSERTED;
						position = oblu_pkg::POS_W'(iidx);
						cnt_nx   = cnt_q + CW'(1);
					end
				end
				oblu_pkg::KIND_CLEAR: begin
					action = oblu_pkg::ACT_CLEARED;
					cnt_nx = '0;
				end
				oblu_pkg::KIND_APPEND: begin
					if (!full) begin
						do_app   = 1'b1;
						action   = oblu_pkg::ACT_LOADED;
						position = oblu_pkg::POS_W'(cnt_q);
						cnt_nx   = cnt_q + CW'(1);
					end
				end
				default: begin
					do_top = 1'b1;
					action = oblu_pkg::ACT_UPDATED;
					if (cnt_q == '0) cnt_nx = CW'(1);
				end
			endcase
		end
		if (clr) cnt_nx = '0;
		depth_nx = oblu_pkg::POS_W'(cnt_nx);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (do_del && after_m[i] && i + 1 < DEPTH) begin
					pr_q[i] <= pr_q[(i + 1) % DEPTH];
					qt_q[i] <= qt_q[(i + 1) % DEPTH];
				end else if (do_ins && after_i[i] && i > 0) begin
					pr_q[i] <= pr_q[(i + DEPTH - 1) % DEPTH];
					qt_q[i] <= qt_q[(i + DEPTH - 1) % DEPTH];
				end else if ((do_ins && CW'(i) == iidx) || (do_app && CW'(i) == cnt_q)
						|| (do_top && i == 0)) begin
					pr_q[i] <= cmd.price;
					qt_q[i] <= cmd.qty;
				end else if (do_upd && first_m[i]) begin
					qt_q[i] <= cmd.qty;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (en) begin
			cnt_q <= cnt_nx;
		end
	end

	// level 0 as it stands after this item
	always_comb begin
		top_price = pr_q[0];
		top_qty   = qt_q[0];
		if (do_top || (do_ins && iidx == '0) || (do_app && cnt_q == '0)) begin
			top_price = cmd.price;
			top_qty   = cmd.qty;
		end else if (do_upd && first_m[0]) begin
			top_qty = cmd.qty;
		end else if (do_del && first_m[0] && DEPTH > 1) begin
			top_price = pr_q[1 % DEPTH];
			top_qty   = qt_q[1 % DEPTH];
		end
		if (cnt_nx == '0) begin
			top_price = '0;
			top_qty   = '0;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/oblu_back.sv
`default_nettype none
module oblu_back #(
	parameter int DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	output logic            q_ready,
	input  wire oblu_pkg::cmd_t q_cmd,
	output logic            out_valid,
	input  wire logic       out_ready,
	output oblu_pkg::res_t  out_res
);
	logic              en, clr;
	oblu_pkg::action_t b_act, a_act;
	logic [oblu_pkg::POS_W-1:0] b_pos, a_pos, b_dep, a_dep;
	logic [oblu_pkg::PRICE_W-1:0] b_pr, a_pr;
	logic [oblu_pkg::QTY_W-1:0]   b_qt, a_qt;
	logic valid_q;
	oblu_pkg::res_t res_q;

	assign q_ready = !valid_q || out_ready;
	assign en      = q_valid && q_ready;
	assign clr     = (q_cmd.kind == oblu_pkg::KIND_CLEAR);

	// the other side only takes part in a clear
	logic b_en, a_en;
	assign b_en = en && (q_cmd.is_bid || clr);
	assign a_en = en && (!q_cmd.is_bid || clr);

	oblu_side #(.DEPTH(DEPTH), .DESC(1'b1)) u_bid (
		.clk(clk), .arst_n(arst_n), .en(b_en), .clr(clr && en), .cmd(q_cmd),
		.action(b_act), .position(b_pos), .depth_nx(b_dep),
		.top_price(b_pr), .top_qty(b_qt)
	);
	oblu_side #(.DEPTH(DEPTH), .DESC(1'b0)) u_ask (
		.clk(clk), .arst_n(arst_n), .en(a_en), .clr(clr && en), .cmd(q_cmd),
		.action(a_act), .position(a_pos), .depth_nx(a_dep),
		.top_price(a_pr), .top_qty(a_qt)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.action         <= q_cmd.is_bid ? b_act : a_act;
			res_q.position       <= q_cmd.is_bid ? b_pos : a_pos;
			res_q.bid_depth      <= b_dep;
			res_q.ask_depth      <= a_dep;
			res_q.best_bid_price <= b_pr;
			res_q.best_bid_qty   <= b_qt;
			res_q.best_ask_price <= a_pr;
			res_q.best_ask_qty   <= a_qt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_ready) begin
			valid_q <= q_valid;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;
endmodule
`default_nettype wire

// File: hw/rtl/order_book_level_update.sv
// an input transfer is written into the queue stage, then the book update registers its result
// throughput: one item per cycle unless the output stalls; each item updates its side's level array when popped
// the two-entry queue decouples input acceptance from result backpressure
// reset: asynchronous active low, both sides empty, queue and output empty
// level storage holds no reset value and is read only below the level count
`default_nettype none
module order_book_level_update #(
	parameter int MAX_LEVELS = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// kind[1:0], is_bid[2]
	input  wire logic [2:0]   s_axis_tuser,
	// price[62:0], qty[125:63], zero pad
	input  wire logic [127:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// action[2:0], position[8:3], bid_depth[14:9], ask_depth[20:15],
	// best_bid_price[83:21], best_bid_qty[146:84], best_ask_price[209:147],
	// best_ask_qty[272:210], zero pad
	output logic [279:0]      m_axis_tdata
);
	logic           q_valid, q_ready;
	oblu_pkg::cmd_t q_cmd;
	oblu_pkg::res_t res;
	logic           unused;

	oblu_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_user(s_axis_tuser), .in_data(s_axis_tdata[125:0]),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
	);

	oblu_back #(.DEPTH(MAX_LEVELS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign unused = ^s_axis_tdata[127:126];
	assign m_axis_tdata = {7'd0, res.best_ask_qty, res.best_ask_price, res.best_bid_qty,
		res.best_bid_price, res.ask_depth, res.bid_depth, res.position, res.action};
endmodule
`default_nettype wire

// File: hw/rtl/oblu_checker.sv
`default_nettype none
module oblu_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [279:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2:0] == oblu_pkg::ACT_CLEARED |->
		m_axis_tdata[20:3] == '0)
		else $error("clear left levels");
	a_empty_bid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[14:9] == '0 |-> m_axis_tdata[146:21] == '0)
		else $error("empty bid side shows a level");
	a_empty_ask: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[20:15] == '0 |-> m_axis_tdata[272:147] == '0)
		else $error("empty ask side shows a level");
endmodule

bind order_book_level_update oblu_checker u_oblu_checker (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// File: dv/tb_order_book_level_update.sv
`timescale 1ns / 1ps
module tb_order_book_level_update;

	localparam int DEPTH = 32;
	localparam int POOL = 40;
	localparam int LIMIT = 400000;

	typedef struct {
		oblu_pkg::kind_t  kind;
		bit               is_bid;
		logic [62:0]      price;
		logic [62:0]      qty;
	} book_cmd_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [2:0]   s_axis_tuser = '0;
	logic [127:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [279:0] m_axis_tdata;

	order_book_level_update #(.MAX_LEVELS(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	book_cmd_t      feed_q[$];
	oblu_pkg::res_t book_res_q[$];
	logic [62:0] bid_px[DEPTH], bid_sz[DEPTH], ask_px[DEPTH], ask_sz[DEPTH];
	int        bid_n = 0, ask_n = 0;
	logic [62:0] bid_pool[POOL], ask_pool[POOL];
	int        errors = 0;
	int        cycles = 0;
	int        sent = 0;
	int        in_gap = 0, out_gap = 0;
	bit        took = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic logic [62:0] rand63();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[62:0];
	endfunction

	function automatic int pick_gap(int n);
		int r;
		if ((n / 64) % 3 == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(15, 50);
	endfunction

	function automatic oblu_pkg::res_t book_apply(book_cmd_t c);
		oblu_pkg::res_t r;
		int n, at, i, hit;
		logic [62:0] px[DEPTH], sz[DEPTH];
		r = '0;
		r.action = oblu_pkg::ACT_IGNORED;
		r.position = '0;
		if (c.is_bid) begin
			px = bid_px; sz = bid_sz; n = bid_n;
		end else begin
			px = ask_px; sz = ask_sz; n = ask_n;
		end
		case (c.kind)
			oblu_pkg::KIND_DELTA: begin
				hit = -1;
				for (i = 0; i < n; i++)
					if (hit < 0 && px[i] == c.price) hit = i;
				if (hit >= 0) begin
					r.position = 6'(hit);
					if (c.qty == 0) begin
						for (i = hit; i + 1 < n; i++) begin
							px[i] = px[i+1]; sz[i] = sz[i+1];
						end
						n--;
						r.action = oblu_pkg::ACT_DELETED;
					end else begin
						sz[hit] = c.qty;
						r.action = oblu_pkg::ACT_UPDATED;
					end
				end else if (c.qty != 0 && n < DEPTH) begin
					at = n;
					for (i = n - 1; i >= 0; i--)
						if (c.is_bid ? (c.price > px[i]) : (c.price < px[i])) at = i;
					for (i = n; i > at; i--) begin
						px[i] = px[i-1]; sz[i] = sz[i-1];
					end
					px[at] = c.price; sz[at] = c.qty;
					n++;
					r.position = 6'(at);
					r.action = oblu_pkg::ACT_INSERTED;
				end
			end
			oblu_pkg::KIND_CLEAR: begin
				bid_n = 0; ask_n = 0; n = 0;
				r.action = oblu_pkg::ACT_CLEARED;
			end
			oblu_pkg::KIND_APPEND: begin
				if (n < DEPTH) begin
					r.position = 6'(n);
					px[n] = c.price; sz[n] = c.qty;
					n++;
					r.action = oblu_pkg::ACT_LOADED;
				end
			end
			default: begin
				px[0] = c.price; sz[0] = c.qty;
				if (n == 0) n = 1;
				r.action = oblu_pkg::ACT_UPDATED;
			end
		endcase
		if (c.is_bid) begin
			bid_px = px; bid_sz = sz; bid_n = n;
		end else begin
			ask_px = px; ask_sz = sz; ask_n = n;
		end
		r.bid_depth = 6'(bid_n);
		r.ask_depth = 6'(ask_n);
		if (bid_n != 0) begin
			r.best_bid_price = bid_px[0]; r.best_bid_qty = bid_sz[0];
		end
		if (ask_n != 0) begin
			r.best_ask_price = ask_px[0]; r.best_ask_qty = ask_sz[0];
		end
		return r;
	endfunction

	task automatic add(oblu_pkg::kind_t k, bit b, logic [62:0] p, logic [62:0] q);
		book_cmd_t c;
		c.kind = k; c.is_bid = b; c.price = p; c.qty = q;
		feed_q.push_back(c);
	endtask

	// driver
	always @(posedge clk) begin
		took <= s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			book_res_q.push_back(book_apply(feed_q[0]));
			feed_q.pop_front();
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || took)) begin
			if (in_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (feed_q.size() > 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= {feed_q[0].is_bid, feed_q[0].kind};
				s_axis_tdata <= {2'b0, feed_q[0].qty, feed_q[0].price};
				in_gap <= pick_gap(sent);
				sent <= sent + 1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				m_axis_tready <= 1'b0;
				out_gap <= out_gap - 1;
			end else begin
				m_axis_tready <= 1'b1;
				out_gap <= pick_gap(sent + 32);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		oblu_pkg::res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.action         = oblu_pkg::action_t'(m_axis_tdata[2:0]);
			got.position       = m_axis_tdata[8:3];
			got.bid_depth      = m_axis_tdata[14:9];
			got.ask_depth      = m_axis_tdata[20:15];
			got.best_bid_price = m_axis_tdata[83:21];
			got.best_bid_qty   = m_axis_tdata[146:84];
			got.best_ask_price = m_axis_tdata[209:147];
			got.best_ask_qty   = m_axis_tdata[272:210];
			if (book_res_q.size() == 0) begin
				$display("%0t: unexpected transfer %h", $time, got);
				errors++;
			end else begin
				want = book_res_q.pop_front();
				if (got.action !== want.action) begin
					$display("%0t: action exp %0d got %0d", $time, want.action, got.action);
					errors++;
				end
				if (got.position !== want.position) begin
					$display("%0t: position exp %0d got %0d", $time, want.position,
						got.position);
					errors++;
				end
				if (got.bid_depth !== want.bid_depth) begin
					$display("%0t: bid_depth exp %0d got %0d", $time, want.bid_depth,
						got.bid_depth);
					errors++;
				end
				if (got.ask_depth !== want.ask_depth) begin
					$display("%0t: ask_depth exp %0d got %0d", $time, want.ask_depth,
						got.ask_depth);
					errors++;
				end
				if (got.best_bid_price !== want.best_bid_price) begin
					$display("%0t: best_bid_price exp %h got %h", $time,
						want.best_bid_price, got.best_bid_price);
					errors++;
				end
				if (got.best_bid_qty !== want.best_bid_qty) begin
					$display("%0t: best_bid_qty exp %h got %h", $time,
						want.best_bid_qty, got.best_bid_qty);
					errors++;
				end
				if (got.best_ask_price !== want.best_ask_price) begin
					$display("%0t: best_ask_price exp %h got %h", $time,
						want.best_ask_price, got.best_ask_price);
					errors++;
				end
				if (got.best_ask_qty !== want.best_ask_qty) begin
					$display("%0t: best_ask_qty exp %h got %h", $time,
						want.best_ask_qty, got.best_ask_qty);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int i, r;
		bit side;
		logic [62:0] p, q;
		for (i = 0; i < POOL; i++) begin
			bid_pool[i] = rand63();
			ask_pool[i] = rand63();
		end
		// directed
		add(oblu_pkg::KIND_TOP, 1'b1, 63'd500, 63'd0);
		add(oblu_pkg::KIND_TOP, 1'b0, '1, '1);
		add(oblu_pkg::KIND_DELTA, 1'b1, 63'd500, 63'd7);
		add(oblu_pkg::KIND_DELTA, 1'b1, '1, 63'd1);
		add(oblu_pkg::KIND_DELTA, 1'b1, 63'd0, '1);
		add(oblu_pkg::KIND_DELTA, 1'b1, 63'd300, 63'd3);
		add(oblu_pkg::KIND_DELTA, 1'b0, 63'd0, 63'd9);
		add(oblu_pkg::KIND_DELTA, 1'b0, 63'd100, 63'd4);
		add(oblu_pkg::KIND_DELTA, 1'b1, 63'd300, 63'd0);
		add(oblu_pkg::KIND_DELTA, 1'b1, 63'd301, 63'd0);
		add(oblu_pkg::KIND_DELTA, 1'b0, '1, 63'd0);
		add(oblu_pkg::KIND_APPEND, 1'b0, 63'd50, 63'd2);
		add(oblu_pkg::KIND_APPEND, 1'b0, 63'd50, 63'd5);
		add(oblu_pkg::KIND_DELTA, 1'b0, 63'd50, 63'd0);
		add(oblu_pkg::KIND_DELTA, 1'b0, 63'd50, 63'd11);
		add(oblu_pkg::KIND_TOP, 1'b1, 63'd999, 63'd0);
		add(oblu_pkg::KIND_CLEAR, 1'b0, '1, '1);
		add(oblu_pkg::KIND_DELTA, 1'b0, 63'd5, 63'd0);
		add(oblu_pkg::KIND_APPEND, 1'b1, 63'd8, 63'd8);
		add(oblu_pkg::KIND_CLEAR, 1'b1, 63'd0, 63'd0);
		// random: mostly deltas on a small price pool so sides fill and match
		for (i = 0; i < 750; i++) begin
			r = $urandom_range(0, 199);
			side = ($urandom_range(0, 1) != 0);
			p = side ? bid_pool[$urandom_range(0, POOL - 1)]
				: ask_pool[$urandom_range(0, POOL - 1)];
			q = ($urandom_range(0, 3) == 0) ? 63'd0 : rand63();
			if (r < 3)
				add(oblu_pkg::KIND_CLEAR, side, rand63(), rand63());
			else if (r < 18)
				add(oblu_pkg::KIND_APPEND, side, ($urandom_range(0, 1) ? p : rand63()), q);
			else if (r < 28)
				add(oblu_pkg::KIND_TOP, side, p, q);
			else if (r < 40)
				add(oblu_pkg::KIND_DELTA, side, rand63(), q);
			else
				add(oblu_pkg::KIND_DELTA, side, p, q);
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (feed_q.size() != 0 || book_res_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: order_book_level_update.f
hw/rtl/oblu_pkg.sv
hw/rtl/oblu_front.sv
hw/rtl/oblu_side.sv
hw/rtl/oblu_back.sv
hw/rtl/order_book_level_update.sv
hw/rtl/oblu_checker.sv
dv/tb_order_book_level_update.sv
